[rtl/cll_pkg.sv]
`default_nettype none

package cll_pkg;

  localparam int CELLS_DEFAULT = 16;

  localparam int VALUE_W      = 32;
  localparam int REQ_W        = 3;
  localparam int STATUS_W     = 2;
  localparam int CELL_IDX_W   = 4;
  localparam int COUNT_W      = 5;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_FIELDS_W = VALUE_W + CELL_IDX_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [REQ_W-1:0] REQ_INS_HEAD   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_SORTED = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FIRST  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_ALL    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_WALK       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_INS,
    S_LINKP,
    S_SCAN,
    S_UNLINK,
    S_WALK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

[rtl/cll_mem.sv]
`default_nettype none

module cll_mem #(
  parameter int CELLS = cll_pkg::CELLS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(CELLS)-1:0]    rd_addr,
  output      logic [cll_pkg::VALUE_W-1:0] rd_value,
  output      logic [$clog2(CELLS+1)-1:0]  rd_link,
  input  wire logic                        wv_en,
  input  wire logic [$clog2(CELLS)-1:0]    wv_addr,
  input  wire logic [cll_pkg::VALUE_W-1:0] wv_data,
  input  wire logic                        wl_en,
  input  wire logic [$clog2(CELLS)-1:0]    wl_addr,
  input  wire logic [$clog2(CELLS+1)-1:0]  wl_data
);

  localparam int IW = $clog2(CELLS);
  localparam int LW = $clog2(CELLS + 1);

  logic [cll_pkg::VALUE_W-1:0] val_mem [CELLS];
  logic [LW-1:0]               link_mem [CELLS];

  logic [CELLS-1:0]            lvalid_r;
  logic [cll_pkg::VALUE_W-1:0] rd_value_r;
  logic [LW-1:0]               rd_link_r;
  logic                        rd_lvalid_r;
  logic [IW-1:0]               rd_addr_r;

  always_ff @(posedge clk) begin
    if (wv_en) begin
      val_mem[wv_addr] <= wv_data;
    end
    if (wl_en) begin
      link_mem[wl_addr] <= wl_data;
    end
  end

  // unwritten links read as index plus one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r <= '0;
    end else if (wl_en) begin
      lvalid_r[wl_addr] <= 1'b1;
    end
  end

  // registered read with write-first bypass
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r <= rd_addr;
      if (wv_en && (wv_addr == rd_addr)) begin
        rd_value_r <= wv_data;
      end else begin
        rd_value_r <= val_mem[rd_addr];
      end
      if (wl_en && (wl_addr == rd_addr)) begin
        rd_link_r   <= wl_data;
        rd_lvalid_r <= 1'b1;
      end else begin
        rd_link_r   <= link_mem[rd_addr];
        rd_lvalid_r <= lvalid_r[rd_addr];
      end
    end
  end

  assign rd_value = rd_value_r;
  assign rd_link  = rd_lvalid_r ? rd_link_r : (LW'(rd_addr_r) + LW'(1));

endmodule

`default_nettype wire

[rtl/cursor_linked_list_engine.sv]
// cursor_linked_list_engine
// Singly linked list of signed 32-bit elements in a pool of CELLS cells,
// unused cells on a LIFO free list.
// Input channel in_*: in_tuser carries the request code, in_tdata the value.
// Result channel out_*: out_tuser carries the status, out_tdata the walked
// value, cell index and removed count, out_tlast marks the last item of a
// request.
// One request is worked on at a time; in_tready is high only between
// requests. Every link visited is read through the single read port of
// the link memory: an insert takes the head of the free list, a tail or
// sorted insert walks the list to its place and then links in the
// predecessor, a delete scans the list and unlinks the first or every
// match, and a walk sends one item per element.
// Requests with codes six and seven are dropped with no result.
// Results leave through an output register; while the receiver stalls the
// engine holds its pending result and a walk pauses, and the next request
// waits. Reset empties the list and chains every cell onto the free list
// in index order; the block takes requests right after.
`default_nettype none

module cursor_linked_list_engine #(
  parameter int CELLS = cll_pkg::CELLS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [cll_pkg::IN_TDATA_W-1:0] in_tdata,   // value
  input  wire logic [cll_pkg::REQ_W-1:0]      in_tuser,   // req_type
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // value_out, cell_index, removed_count, zero fill
  output      logic [cll_pkg::OUT_TDATA_W-1:0] out_tdata,
  output      logic [cll_pkg::STATUS_W-1:0]    out_tuser,  // status
  output      logic                            out_tlast   // is_last
);

  localparam int IW = $clog2(CELLS);
  localparam int LW = $clog2(CELLS + 1);
  localparam int CW = $clog2(CELLS + 1);
  localparam logic [LW-1:0] NIL = LW'(CELLS);

  cll_pkg::state_t state_r, state_nxt;

  logic [cll_pkg::REQ_W-1:0]          req_r, req_nxt;
  logic signed [cll_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [LW-1:0]                      list_head_r, list_head_nxt;
  logic [LW-1:0]                      free_head_r, free_head_nxt;
  logic [LW-1:0]                      prev_r, prev_nxt;
  logic [LW-1:0]                      cur_r, cur_nxt;
  logic [LW-1:0]                      next_r, next_nxt;
  logic [IW-1:0]                      cnew_r, cnew_nxt;
  logic [CW-1:0]                      count_r, count_nxt;

  logic [cll_pkg::STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic [IW-1:0]                      res_cell_r, res_cell_nxt;
  logic [CW-1:0]                      res_count_r, res_count_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [cll_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [cll_pkg::VALUE_W-1:0]        out_value_r, out_value_nxt;
  logic [cll_pkg::CELL_IDX_W-1:0]     out_cell_r, out_cell_nxt;
  logic [cll_pkg::COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic                               out_last_r, out_last_nxt;

  logic                               rd_en;
  logic [IW-1:0]                      rd_addr;
  logic [cll_pkg::VALUE_W-1:0]        rd_value;
  logic [LW-1:0]                      rd_link;
  logic                               wv_en;
  logic [IW-1:0]                      wv_addr;
  logic [cll_pkg::VALUE_W-1:0]        wv_data;
  logic                               wl_en;
  logic [IW-1:0]                      wl_addr;
  logic [LW-1:0]                      wl_data;

  logic                               in_acc;
  logic                               out_free;
  logic                               is_insert;
  logic                               is_delete;
  logic                               ins_here;
  logic                               match;

  cll_mem #(
    .CELLS(CELLS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_link  (rd_link),
    .wv_en    (wv_en),
    .wv_addr  (wv_addr),
    .wv_data  (wv_data),
    .wl_en    (wl_en),
    .wl_addr  (wl_addr),
    .wl_data  (wl_data)
  );

  assign in_tready = (state_r == cll_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign is_insert = (in_tuser == cll_pkg::REQ_INS_HEAD) ||
                     (in_tuser == cll_pkg::REQ_INS_TAIL) ||
                     (in_tuser == cll_pkg::REQ_INS_SORTED);
  assign is_delete = (in_tuser == cll_pkg::REQ_DEL_FIRST) ||
                     (in_tuser == cll_pkg::REQ_DEL_ALL);
  assign ins_here  = (req_r == cll_pkg::REQ_INS_SORTED) &&
                     !($signed(rd_value) < val_r);
  assign match     = (rd_value == val_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cll_pkg::S_IDLE: begin
        if (in_acc) begin
          if (is_insert) begin
            state_nxt = (free_head_r == NIL) ? cll_pkg::S_RESP : cll_pkg::S_ALLOC;
          end else if (is_delete) begin
            state_nxt = (list_head_r == NIL) ? cll_pkg::S_RESP : cll_pkg::S_SCAN;
          end else if (in_tuser == cll_pkg::REQ_WALK) begin
            state_nxt = (list_head_r == NIL) ? cll_pkg::S_RESP : cll_pkg::S_WALK;
          end
        end
      end
      cll_pkg::S_ALLOC: begin
        if ((req_r == cll_pkg::REQ_INS_HEAD) || (list_head_r == NIL)) begin
          state_nxt = cll_pkg::S_RESP;
        end else begin
          state_nxt = cll_pkg::S_INS;
        end
      end
      cll_pkg::S_INS: begin
        if (ins_here || (rd_link == NIL)) begin
          state_nxt = cll_pkg::S_LINKP;
        end
      end
      cll_pkg::S_LINKP: begin
        state_nxt = cll_pkg::S_RESP;
      end
      cll_pkg::S_SCAN: begin
        if (match) begin
          state_nxt = cll_pkg::S_UNLINK;
        end else if (rd_link == NIL) begin
          state_nxt = cll_pkg::S_RESP;
        end
      end
      cll_pkg::S_UNLINK: begin
        if ((req_r == cll_pkg::REQ_DEL_FIRST) || (next_r == NIL)) begin
          state_nxt = cll_pkg::S_RESP;
        end else begin
          state_nxt = cll_pkg::S_SCAN;
        end
      end
      cll_pkg::S_WALK: begin
        if (out_free && (rd_link == NIL)) begin
          state_nxt = cll_pkg::S_IDLE;
        end
      end
      cll_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = cll_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cll_pkg::S_IDLE;
      end
    endcase
  end

  // datapath, memory ports and result register
  always_comb begin
    req_nxt        = req_r;
    val_nxt        = val_r;
    list_head_nxt  = list_head_r;
    free_head_nxt  = free_head_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    next_nxt       = next_r;
    cnew_nxt       = cnew_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_cell_nxt   = res_cell_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_cell_nxt   = out_cell_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = cur_r[IW-1:0];
    wv_en          = 1'b0;
    wv_addr        = cnew_r;
    wv_data        = val_r;
    wl_en          = 1'b0;
    wl_addr        = cnew_r;
    wl_data        = NIL;

    case (state_r)
      cll_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt       = in_tuser;
          val_nxt       = in_tdata;
          prev_nxt      = NIL;
          cur_nxt       = list_head_r;
          count_nxt     = '0;
          res_cell_nxt  = '0;
          res_count_nxt = '0;
          if (is_insert) begin
            res_status_nxt = cll_pkg::ST_POOL_FULL;
            if (free_head_r != NIL) begin
              cnew_nxt = free_head_r[IW-1:0];
              rd_en    = 1'b1;
              rd_addr  = free_head_r[IW-1:0];
              wv_en    = 1'b1;
              wv_addr  = free_head_r[IW-1:0];
              wv_data  = in_tdata;
            end
          end else if (is_delete) begin
            res_status_nxt = cll_pkg::ST_NOT_FOUND;
            rd_en          = (list_head_r != NIL);
            rd_addr        = list_head_r[IW-1:0];
          end else begin
            res_status_nxt = cll_pkg::ST_EMPTY;
            rd_en          = (list_head_r != NIL);
            rd_addr        = list_head_r[IW-1:0];
          end
        end
      end
      cll_pkg::S_ALLOC: begin
        free_head_nxt  = rd_link;
        res_status_nxt = cll_pkg::ST_OK;
        res_cell_nxt   = cnew_r;
        if ((req_r == cll_pkg::REQ_INS_HEAD) || (list_head_r == NIL)) begin
          wl_en         = 1'b1;
          wl_addr       = cnew_r;
          wl_data       = list_head_r;
          list_head_nxt = LW'(cnew_r);
        end else begin
          prev_nxt = NIL;
          cur_nxt  = list_head_r;
          rd_en    = 1'b1;
          rd_addr  = list_head_r[IW-1:0];
        end
      end
      cll_pkg::S_INS: begin
        if (ins_here) begin
          wl_en   = 1'b1;
          wl_addr = cnew_r;
          wl_data = cur_r;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = rd_link;
          if (rd_link == NIL) begin
            wl_en   = 1'b1;
            wl_addr = cnew_r;
            wl_data = NIL;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_link[IW-1:0];
          end
        end
      end
      cll_pkg::S_LINKP: begin
        if (prev_r == NIL) begin
          list_head_nxt = LW'(cnew_r);
        end else begin
          wl_en   = 1'b1;
          wl_addr = prev_r[IW-1:0];
          wl_data = LW'(cnew_r);
        end
      end
      cll_pkg::S_SCAN: begin
        if (match) begin
          // push the cell on the free list, relink its predecessor next
          wl_en         = 1'b1;
          wl_addr       = cur_r[IW-1:0];
          wl_data       = free_head_r;
          free_head_nxt = cur_r;
          next_nxt      = rd_link;
          count_nxt     = count_r + CW'(1);
          if (prev_r == NIL) begin
            list_head_nxt = rd_link;
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = rd_link;
          if (rd_link == NIL) begin
            res_status_nxt = (count_r != '0) ? cll_pkg::ST_OK : cll_pkg::ST_NOT_FOUND;
            res_cell_nxt   = '0;
            res_count_nxt  = count_r;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_link[IW-1:0];
          end
        end
      end
      cll_pkg::S_UNLINK: begin
        if (prev_r != NIL) begin
          wl_en   = 1'b1;
          wl_addr = prev_r[IW-1:0];
          wl_data = next_r;
        end
        res_status_nxt = cll_pkg::ST_OK;
        res_count_nxt  = count_r;
        if (req_r == cll_pkg::REQ_DEL_FIRST) begin
          res_cell_nxt = cur_r[IW-1:0];
        end else begin
          res_cell_nxt = '0;
          cur_nxt      = next_r;
          rd_en        = (next_r != NIL);
          rd_addr      = next_r[IW-1:0];
        end
      end
      cll_pkg::S_WALK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cll_pkg::ST_OK;
          out_value_nxt  = rd_value;
          out_cell_nxt   = cll_pkg::CELL_IDX_W'(cur_r[IW-1:0]);
          out_count_nxt  = '0;
          out_last_nxt   = (rd_link == NIL);
          cur_nxt        = rd_link;
          rd_en          = (rd_link != NIL);
          rd_addr        = rd_link[IW-1:0];
        end
      end
      cll_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = '0;
          out_cell_nxt   = cll_pkg::CELL_IDX_W'(res_cell_r);
          out_count_nxt  = cll_pkg::COUNT_W'(res_count_r);
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cll_pkg::S_IDLE;
      list_head_r <= NIL;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    val_r        <= val_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    next_r       <= next_nxt;
    cnew_r       <= cnew_nxt;
    count_r      <= count_nxt;
    res_status_r <= res_status_nxt;
    res_cell_r   <= res_cell_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_cell_r   <= out_cell_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{cll_pkg::OUT_PAD_W{1'b0}}, out_count_r, out_cell_r, out_value_r};

  // the list head is never also the head of the free list
  a_heads_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (list_head_r != NIL) |-> (list_head_r != free_head_r))
    else $error("list head is also the free head");

  // the freshly allocated cell is not part of the list
  a_alloc_off_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cll_pkg::S_ALLOC) |-> (LW'(cnew_r) != list_head_r))
    else $error("allocated cell already heads the list");

  // only a walk produces items that are not the last of a request
  a_nonlast_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !out_last_r) |-> (state_r == cll_pkg::S_WALK))
    else $error("non-last item outside a walk");

  // deletes never free more cells than the pool holds
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == cll_pkg::S_SCAN) || (state_r == cll_pkg::S_UNLINK)) |->
      (count_r <= CW'(CELLS)))
    else $error("removed count beyond pool size");

endmodule

`default_nettype wire
